// ===== rtl/ssbs_pkg.sv =====
// Shared types and constants for the sample set statistics block.
// Used by ssbs_ctrl, ssbs_datapath, the top level and the bench; depends on nothing else.
package ssbs_pkg;

  // Sample word width and default buffer depth.
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned MAX_SAMPLES_DEF = 1024;

  // Fixed result field widths.
  localparam int unsigned COUNT_OUT_W = 11;
  localparam int unsigned VAR_W       = 35;
  localparam int unsigned SD_W        = 18;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SINGLE  = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  // One input transaction.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic        [COUNT_OUT_W-1:0] sample_count;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic        [VAR_W-1:0]       variance;
    logic        [SD_W-1:0]        std_dev;
    logic        [1:0]             status;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_set;
    logic div_start;
    logic div_var;
    logic mean_load;
    logic pass_clr;
    logic rd_en;
    logic var_load;
    logic sqrt_start;
    logic sd_load;
    logic out_fire;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic rd_at_last;
    logic pipe_empty;
    logic multi;
  } sts_t;

endpackage

// ===== rtl/ssbs_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing; used by ssbs_datapath.
module ssbs_div #(
  parameter int unsigned N = 45,
  parameter int unsigned M = 11
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [M-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(N);

  logic [N-1:0]     quo_q;
  logic [M-1:0]     rem_q;
  logic [M-1:0]     dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [M:0]       rem_sh;
  logic             ge;
  logic [M:0]       rem_sub;

  // Shift in the next dividend bit and try to subtract.
  assign rem_sh  = {rem_q, quo_q[N-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // One step per cycle; the dividend register fills with quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[N-2:0], ge};
        rem_q <= ge ? rem_sub[M-1:0] : rem_sh[M-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/ssbs_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
// Depends on nothing; used by ssbs_datapath.
module ssbs_sqrt #(
  parameter int unsigned RW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] radicand_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);

  localparam int unsigned CNT_W = $clog2(RW);

  logic [2*RW-1:0]  rad_q;
  logic [RW:0]      rem_q;
  logic [RW-1:0]    root_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [RW+2:0]    rem_sh;
  logic [RW+2:0]    trial;
  logic [RW+2:0]    rem_sub;
  logic             ge;

  // Bring down two radicand bits and test the trial value 4*root+1.
  assign rem_sh  = {rem_q, rad_q[2*RW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  // One root bit per cycle, most significant first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= {rad_q[2*RW-3:0], 2'b00};
        rem_q  <= ge ? rem_sub[RW:0] : rem_sh[RW:0];
        root_q <= {root_q[RW-2:0], ge};
        cnt_q  <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/ssbs_ctrl.sv =====
// Controller state machine for the sample set statistics block.
// Depends on ssbs_pkg for the command and status structs.
module ssbs_ctrl import ssbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic last_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  typedef enum logic [8:0] {
    S_LOAD      = 9'b000000001,
    S_MEAN_GO   = 9'b000000010,
    S_MEAN_WAIT = 9'b000000100,
    S_PASS      = 9'b000001000,
    S_DRAIN     = 9'b000010000,
    S_VAR_GO    = 9'b000100000,
    S_VAR_WAIT  = 9'b001000000,
    S_SQRT_WAIT = 9'b010000000,
    S_OUT       = 9'b100000000
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (last_i) begin
            state_d = S_MEAN_GO;
          end
        end
      end
      S_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.mean_load = 1'b1;
          cmd_o.pass_clr  = 1'b1;
          state_d         = S_PASS;
        end
      end
      S_PASS: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.rd_at_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = sts_i.multi ? S_VAR_GO : S_OUT;
        end
      end
      S_VAR_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_var   = 1'b1;
        state_d         = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.var_load   = 1'b1;
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.sd_load = 1'b1;
          state_d       = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.out_fire  = 1'b1;
        cmd_o.clear_set = 1'b1;
        state_d         = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ssbs_datapath.sv =====
// Datapath: sample buffer, running min/max/sum, deviation pass, shared divider
// and square root, result register. Depends on ssbs_pkg, ssbs_div, ssbs_sqrt.
module ssbs_datapath import ssbs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  item_t   item_i,
  output sts_t    sts_o,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam int unsigned SW = SB + CW;
  localparam int unsigned DW = SB + 1;
  localparam int unsigned QW = 2 * DW;
  localparam int unsigned AW = QW + CW;
  localparam int unsigned RW = SD_W;

  // Running set state.
  logic        [CW-1:0] cnt_q;
  logic signed [SB-1:0] min_q;
  logic signed [SB-1:0] max_q;
  logic signed [SW-1:0] sum_q;
  logic                 ovf_q;
  logic                 keep;
  logic signed [SW-1:0] sample_ext;

  // Sample buffer and deviation pass.
  logic        [SB-1:0] mem [MAX_SAMPLES];
  logic        [SB-1:0] rdata_q;
  logic        [IW-1:0] rd_addr_q;
  logic                 rd_vld_q;
  logic signed [DW-1:0] diff;
  logic signed [QW-1:0] prod;
  logic        [QW-1:0] sq_q;
  logic                 sq_vld_q;
  logic        [AW-1:0] acc_q;

  // Division, root and results.
  logic                 sum_neg;
  logic        [SW-1:0] abs_sum;
  logic        [AW-1:0] div_dividend;
  logic        [CW-1:0] div_divisor;
  logic                 div_done;
  logic        [AW-1:0] div_quo;
  logic        [SB-1:0] quo_mag;
  logic        [VAR_W-1:0] sat_var;
  logic                 sqrt_done;
  logic        [RW-1:0] sqrt_root;
  logic signed [SB-1:0] mean_q;
  logic        [VAR_W-1:0] var_q;
  logic        [RW-1:0] sd_q;
  status_e              status;
  result_t              res_q;
  logic                 result_valid_q;

  // A sample is kept only while the buffer has room.
  assign keep       = cmd_i.accept && (cnt_q < CW'(MAX_SAMPLES));
  assign sample_ext = {{CW{item_i.sample[SB-1]}}, item_i.sample};

  // Running count, min, max, sum and overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      min_q <= {1'b0, {(SB-1){1'b1}}};
      max_q <= {1'b1, {(SB-1){1'b0}}};
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear_set) begin
      cnt_q <= '0;
      min_q <= {1'b0, {(SB-1){1'b1}}};
      max_q <= {1'b1, {(SB-1){1'b0}}};
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (keep) begin
      cnt_q <= cnt_q + CW'(1);
      sum_q <= sum_q + sample_ext;
      if (item_i.sample < min_q) begin
        min_q <= item_i.sample;
      end
      if (item_i.sample > max_q) begin
        max_q <= item_i.sample;
      end
    end else if (cmd_i.accept) begin
      ovf_q <= 1'b1;
    end
  end

  // Sample buffer: written while loading, read during the deviation pass.
  always_ff @(posedge clk_i) begin
    if (keep) begin
      mem[cnt_q[IW-1:0]] <= item_i.sample;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_q];
    end
  end

  // Deviation from the mean and its square.
  assign diff = $signed({rdata_q[SB-1], rdata_q}) - $signed({mean_q[SB-1], mean_q});
  assign prod = diff * diff;

  // Read address, pipeline valids and squared-deviation accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      sq_q      <= '0;
      acc_q     <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      sq_vld_q <= rd_vld_q;
      sq_q     <= $unsigned(prod);
      if (cmd_i.pass_clr) begin
        rd_addr_q <= '0;
        acc_q     <= '0;
      end else begin
        if (cmd_i.rd_en) begin
          rd_addr_q <= rd_addr_q + IW'(1);
        end
        if (sq_vld_q) begin
          acc_q <= acc_q + {{CW{1'b0}}, sq_q};
        end
      end
    end
  end

  // Divider operands: magnitude of the sum over the count for the mean,
  // squared-deviation sum over count minus one for the variance.
  assign sum_neg      = sum_q[SW-1];
  assign abs_sum      = sum_neg ? $unsigned(-sum_q) : $unsigned(sum_q);
  assign div_dividend = cmd_i.div_var ? acc_q : {{(AW-SW){1'b0}}, abs_sum};
  assign div_divisor  = cmd_i.div_var ? (cnt_q - CW'(1)) : cnt_q;

  ssbs_div #(
    .N (AW),
    .M (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Mean restores the sign; variance saturates at its field width.
  assign quo_mag = div_quo[SB-1:0];
  assign sat_var = (|div_quo[AW-1:VAR_W]) ? {VAR_W{1'b1}} : div_quo[VAR_W-1:0];

  ssbs_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i ({{(2*RW-VAR_W){1'b0}}, sat_var}),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // Mean, variance and deviation registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      var_q  <= '0;
      sd_q   <= '0;
    end else begin
      if (cmd_i.mean_load) begin
        mean_q <= sum_neg ? $signed(-quo_mag) : $signed(quo_mag);
      end
      if (cmd_i.pass_clr) begin
        var_q <= '0;
        sd_q  <= '0;
      end else begin
        if (cmd_i.var_load) begin
          var_q <= sat_var;
        end
        if (cmd_i.sd_load) begin
          sd_q <= sqrt_root;
        end
      end
    end
  end

  // Dropped samples take precedence over the single-sample flag.
  always_comb begin
    if (ovf_q) begin
      status = ST_DROPPED;
    end else if (cnt_q == CW'(1)) begin
      status = ST_SINGLE;
    end else begin
      status = ST_OK;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.out_fire;
      if (cmd_i.out_fire) begin
        res_q.sample_count <= COUNT_OUT_W'(cnt_q);
        res_q.min_value    <= min_q;
        res_q.max_value    <= max_q;
        res_q.mean_value   <= mean_q;
        res_q.variance     <= var_q;
        res_q.std_dev      <= sd_q;
        res_q.status       <= status;
      end
    end
  end

  // Status to the controller.
  assign sts_o.div_done   = div_done;
  assign sts_o.sqrt_done  = sqrt_done;
  assign sts_o.rd_at_last = (CW'(rd_addr_q) == (cnt_q - CW'(1)));
  assign sts_o.pipe_empty = !rd_vld_q && !sq_vld_q;
  assign sts_o.multi      = (cnt_q > CW'(1));

  assign result_valid_o = result_valid_q;
  assign result_o       = res_q;

  // The result strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe held for more than one cycle");

  // The deviation pass reads only entries written in this set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (CW'(rd_addr_q) < cnt_q))
    else $error("buffer read beyond the stored samples");

  // The kept count never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SAMPLES))
    else $error("sample count exceeds buffer depth");

  // A single-sample result carries zero variance and deviation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && (res_q.status == ST_SINGLE))
      |-> (res_q.variance == '0) && (res_q.std_dev == '0))
    else $error("single-sample result with nonzero spread");

endmodule

// ===== rtl/sample_set_basic_statistics_top.sv =====
// Sample set statistics, top level. Loads one sample per cycle while busy is
// low. After the sample marked last, the result follows the mean division, the
// buffer read pass and, for a set of more than one sample, the variance division
// on the same bit-serial divider and then the bit-serial square root.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Asynchronous active-low reset empties the set; buffer contents are not cleared.
module sample_set_basic_statistics_top import ssbs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    result_valid_o,
  output result_t result_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of load, mean, deviation pass, variance and root.
  ssbs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .last_i  (item_i.last),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Storage and arithmetic.
  ssbs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== bench/tb_sample_set_basic_statistics_top.sv =====
// Self-checking testbench for the sample set statistics block.
// Walks a short table of directed sets, one set past capacity, then random sets, against its own predictor.
// Depends on ssbs_pkg and sample_set_basic_statistics_top.
module tb_sample_set_basic_statistics_top;
  import ssbs_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SMP_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int      MAX_REPORTS = 10;
  localparam int      TAIL_CYCLES = MAX_SAMPLES_DEF + 128;
  localparam int      LIMIT_CYCLES = 400000;
  localparam int      NUM_DIRECTED = 18;

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    sample_t smp;
    bit      lst;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    result_valid_o;
  result_t result_o;

  // Predictor copy of the set being loaded.
  sample_t set_buf [MAX_SAMPLES_DEF];
  int      set_count;
  longint  set_min;
  longint  set_max;
  longint  set_sum;
  bit      set_dropped;

  result_t   pending_stats[$];
  int        fail_cnt;
  int        idle_pct;
  stim_row_t dir_rows [NUM_DIRECTED];

  sample_set_basic_statistics_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(8 * LIMIT_CYCLES);
    $display("DONE: errors detected");
    $finish;
  end

  // Empties the predicted set after each result.
  function automatic void clear_stats();
    set_count   = 0;
    set_min     = SMP_MAX;
    set_max     = SMP_MIN;
    set_sum     = 0;
    set_dropped = 1'b0;
  endfunction

  // Adds one sample to the predicted set; returns 1 with the statistics when it closes the set.
  function automatic bit absorb_sample(input item_t it, output result_t res);
    longint              s;
    longint              avg;
    longint              d;
    longint unsigned     sq_sum;
    longint unsigned     var_raw;
    longint unsigned     root;
    longint unsigned     trial;
    int                  k;
    res = '0;
    s   = it.sample;
    if (set_count < MAX_SAMPLES_DEF) begin
      set_buf[set_count] = it.sample;
      set_count++;
      set_sum += s;
      if (s < set_min) set_min = s;
      if (s > set_max) set_max = s;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last) return 1'b0;

    // Mean truncates toward zero, as signed division does.
    avg    = set_sum / set_count;
    sq_sum = 0;
    for (k = 0; k < set_count; k++) begin
      d       = longint'(set_buf[k]) - avg;
      sq_sum += longint'(d * d);
    end

    var_raw = 0;
    root    = 0;
    if (set_count > 1) begin
      var_raw = sq_sum / longint'(set_count - 1);
      if (var_raw > (64'd1 << VAR_W) - 1) var_raw = (64'd1 << VAR_W) - 1;
      // Integer square root, one result bit at a time from the top.
      for (k = SD_W - 1; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (trial * trial <= var_raw) root = trial;
      end
    end

    res.sample_count = set_count[COUNT_OUT_W-1:0];
    res.min_value    = set_min[SAMPLE_BITS-1:0];
    res.max_value    = set_max[SAMPLE_BITS-1:0];
    res.mean_value   = avg[SAMPLE_BITS-1:0];
    res.variance     = var_raw[VAR_W-1:0];
    res.std_dev      = root[SD_W-1:0];
    if (set_dropped) res.status = ST_DROPPED;
    else if (set_count == 1) res.status = ST_SINGLE;
    else res.status = ST_OK;
    clear_stats();
    return 1'b1;
  endfunction

  // Result of a set made of one sample: readable straight off the input.
  function automatic result_t single_res(input sample_t smp);
    result_t r;
    r              = '0;
    r.sample_count = COUNT_OUT_W'(1);
    r.min_value    = smp;
    r.max_value    = smp;
    r.mean_value   = smp;
    r.status       = ST_SINGLE;
    return r;
  endfunction

  // Draws a sample: full-range bits, a cluster, an extreme, or a small value.
  function automatic sample_t random_sample(input int mode, input int centre, input int spread);
    case (mode)
      0: return sample_t'($urandom());
      1: return sample_t'(centre + int'($urandom_range(2 * spread)) - spread);
      2: begin
        case ($urandom_range(3))
          0:       return SMP_MIN;
          1:       return SMP_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return sample_t'(int'($urandom_range(512)) - 256);
    endcase
  endfunction

  function automatic void check_field(input string fname, input logic [63:0] got,
                                      input logic [63:0] want);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  // Each result transaction is held for one cycle; compare it with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_stats.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: result with no prediction waiting: %p", $time, result_o);
      end else begin
        want = pending_stats.pop_front();
        check_field("sample_count", 64'(result_o.sample_count), 64'(want.sample_count));
        check_field("min_value", 64'(result_o.min_value), 64'(want.min_value));
        check_field("max_value", 64'(result_o.max_value), 64'(want.max_value));
        check_field("mean_value", 64'(result_o.mean_value), 64'(want.mean_value));
        check_field("variance", 64'(result_o.variance), 64'(want.variance));
        check_field("std_dev", 64'(result_o.std_dev), 64'(want.std_dev));
        check_field("status", 64'(result_o.status), 64'(want.status));
      end
    end
  end

  // Offers one sample, at times after a random idle gap, and waits until it is taken.
  task automatic feed_sample(input sample_t smp, input bit lst, input bit typed,
                             input result_t typed_res);
    item_t   nxt;
    result_t res;
    nxt.sample = smp;
    nxt.last   = lst;
    @(negedge clk_i);
    if (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= nxt;
    do @(posedge clk_i); while (busy);
    if (absorb_sample(nxt, res)) pending_stats.push_back(typed ? typed_res : res);
  endtask

  // Stops offering samples until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  // Random sets, mostly short, some up to a few dozen samples.
  task automatic run_random_sets(input int budget);
    int n;
    int k;
    int mode;
    int centre;
    int spread;
    while (budget > 0) begin
      n = ($urandom_range(7) == 0) ? int'($urandom_range(13, 60)) : int'($urandom_range(1, 12));
      if (n > budget) n = budget;
      mode   = int'($urandom_range(4));
      centre = int'(sample_t'($urandom()));
      spread = 1 << $urandom_range(1, 12);
      for (k = 1; k <= n; k++) begin
        feed_sample(random_sample((mode == 4) ? int'($urandom_range(3)) : mode, centre, spread),
                    k == n, 1'b0, '0);
      end
      budget -= n;
    end
  endtask

  // Main stimulus.
  initial begin
    int k;
    int centre;
    rst_ni   = 1'b0;
    start    = 1'b0;
    item_i   = '0;
    fail_cnt = 0;
    idle_pct = 13;
    clear_stats();

    dir_rows = '{
      // Single-sample sets, the first one straight after reset.
      '{16'sh0100, 1'b1, 1'b1, single_res(16'sh0100)},
      '{SMP_MAX,   1'b1, 1'b1, single_res(SMP_MAX)},
      '{SMP_MIN,   1'b1, 1'b1, single_res(SMP_MIN)},
      '{16'sh0000, 1'b1, 1'b1, single_res(16'sh0000)},
      // Both extremes in one set.
      '{SMP_MIN,   1'b0, 1'b0, '0},
      '{SMP_MAX,   1'b1, 1'b0, '0},
      // Equal samples give zero variance with an ok status.
      '{SMP_MAX,   1'b0, 1'b0, '0},
      '{SMP_MAX,   1'b1, 1'b0, '0},
      '{SMP_MIN,   1'b0, 1'b0, '0},
      '{SMP_MIN,   1'b0, 1'b0, '0},
      '{SMP_MIN,   1'b1, 1'b0, '0},
      // Negative mean that must truncate toward zero.
      '{-16'sd3,   1'b0, 1'b0, '0},
      '{-16'sd2,   1'b1, 1'b0, '0},
      // Small values, all ones, then alternating bit patterns.
      '{16'sh0001, 1'b0, 1'b0, '0},
      '{16'sh0002, 1'b0, 1'b0, '0},
      '{16'shFFFF, 1'b0, 1'b0, '0},
      '{16'sh5555, 1'b0, 1'b0, '0},
      '{16'shAAAA, 1'b1, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < NUM_DIRECTED; k++)
      feed_sample(dir_rows[k].smp, dir_rows[k].lst, dir_rows[k].typed, dir_rows[k].want);

    // One set past capacity: the buffer fills, then the final sample is dropped.
    centre = int'(sample_t'($urandom()));
    for (k = 1; k <= MAX_SAMPLES_DEF + 1; k++)
      feed_sample(random_sample(k % 4, centre, 64), k == MAX_SAMPLES_DEF + 1, 1'b0, '0);

    run_random_sets(110);
    drain_results();

    idle_pct = 63;
    run_random_sets(110);
    drain_results();

    idle_pct = 0;
    run_random_sets(110);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_stats.size() != 0) begin
      fail_cnt++;
      $display("%0d predicted results never arrived", pending_stats.size());
    end
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sample_set_basic_statistics_top.f =====
rtl/ssbs_pkg.sv
rtl/ssbs_div.sv
rtl/ssbs_sqrt.sv
rtl/ssbs_ctrl.sv
rtl/ssbs_datapath.sv
rtl/sample_set_basic_statistics_top.sv
bench/tb_sample_set_basic_statistics_top.sv
